[rtl/core/lifo_rev_pkg.sv]
// Shared types and field constants for the LIFO stack with in-place reverse.
package lifo_rev_pkg;

    localparam int FUNC_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 9;
    localparam int IN_TDATA_W   = 32;
    localparam int RESULT_W     = VALUE_W + STATUS_W + FILL_W + 1;
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_REVERSE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Packed so that the last field, popped_value, lands in the lowest bits.
    typedef struct packed {
        logic                is_empty;
        logic [FILL_W-1:0]   fill_count;
        status_t             status;
        logic [VALUE_W-1:0]  popped_value;
    } result_t;

endpackage

[rtl/core/lifo_stack_with_reverse_top.sv]
// Top level of the LIFO stack with push, pop, clear and in-place reverse.
//
// Usage: each item on the s_ channel carries an operation in s_tuser and a
// push value in s_tdata. Every item yields exactly one item on the m_ channel
// with the popped value, a status code, the fill count and an empty flag.
// The entries live in one synchronous memory with a registered read port.
// Push, clear, a failed pop and a reverse of fewer than two entries give their
// result in the cycle after acceptance. A pop reads the memory into the read
// register and forms its result from it in ST_POP_RD. A reverse of n entries
// swaps floor(n/2) pairs through the read and write ports, each pair in three
// steps (ST_RV_RDJ, ST_RV_WRI and the second write), and then gives its result.
// One item is in work at a time; s_tready is high only while the block is
// idle and the output register is empty or is being emptied in that cycle.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it leaves.
// Reset empties the stack and drops any pending result; the memory contents
// are not cleared, as only entries written by a push are ever read.
module lifo_stack_with_reverse_top
    import lifo_rev_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  logic [FUNC_W-1:0]      s_tuser,   // [1:0] func

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] popped_value, [33:32] status,
                                              // [42:34] fill_count, [43] is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_RV_RDJ,
        ST_RV_WRI
    } state_t;

    // Fifth state kept separate so the enum stays at two bits.
    logic                         rv_wrj_reg, rv_wrj_next;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                i_reg, i_next;
    logic [AW-1:0]                j_reg, j_next;
    logic signed [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    result_t                      result_reg, result_next;
    logic                         m_valid_reg, m_valid_next;

    logic [DATA_WIDTH-1:0]        entry_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;

    logic                         accept;
    func_t                        func_in;
    logic signed [VALUE_W-1:0]    push_value_in;
    logic [CW-1:0]                count_dec;
    logic [AW-1:0]                i_inc;
    logic [AW-1:0]                j_dec;

    assign func_in       = func_t'(s_tuser);
    assign push_value_in = s_tdata[VALUE_W-1:0];
    assign s_tready      = (state_reg == ST_IDLE) && !rv_wrj_reg
                           && (!m_valid_reg || m_tready);
    assign accept        = s_tvalid && s_tready;
    assign count_dec     = count_reg - CW'(1);
    assign i_inc         = i_reg + AW'(1);
    assign j_dec         = j_reg - AW'(1);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        rv_wrj_next  = 1'b0;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        tmp_next     = tmp_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_en        = 1'b0;
        rd_addr      = i_reg;
        wr_en        = 1'b0;
        wr_addr      = i_reg;
        wr_data      = rd_data_reg;

        if (rv_wrj_reg) begin
            // Second write of a swap; the next pair's first read overlaps it.
            wr_en   = 1'b1;
            wr_addr = j_reg;
            wr_data = tmp_reg;
            i_next  = i_inc;
            j_next  = j_dec;
            if (i_inc < j_dec) begin
                rd_en       = 1'b1;
                rd_addr     = i_inc;
                state_next  = ST_RV_RDJ;
            end else begin
                result_next  = '{is_empty: 1'b0, fill_count: FILL_W'(count_reg),
                                 status: STATUS_OK, popped_value: '0};
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        result_next.popped_value = '0;
                        result_next.status       = STATUS_OK;
                        m_valid_next             = 1'b1;
                        unique case (func_in)
                            FUNC_PUSH: begin
                                if (count_reg == COUNT_FULL) begin
                                    result_next.status = STATUS_FULL;
                                end else begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[AW-1:0];
                                    wr_data    = DATA_WIDTH'(push_value_in);
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            FUNC_POP: begin
                                if (count_reg == '0) begin
                                    result_next.status = STATUS_EMPTY;
                                end else begin
                                    rd_en        = 1'b1;
                                    rd_addr      = count_dec[AW-1:0];
                                    count_next   = count_dec;
                                    m_valid_next = 1'b0;
                                    state_next   = ST_POP_RD;
                                end
                            end
                            FUNC_CLEAR: begin
                                count_next = '0;
                            end
                            FUNC_REVERSE: begin
                                if (count_reg > CW'(1)) begin
                                    rd_en        = 1'b1;
                                    rd_addr      = '0;
                                    i_next       = '0;
                                    j_next       = count_dec[AW-1:0];
                                    m_valid_next = 1'b0;
                                    state_next   = ST_RV_RDJ;
                                end
                            end
                            default: begin
                            end
                        endcase
                        result_next.fill_count = FILL_W'(count_next);
                        result_next.is_empty   = (count_next == '0);
                    end
                end
                ST_POP_RD: begin
                    result_next  = '{is_empty: (count_reg == '0),
                                     fill_count: FILL_W'(count_reg),
                                     status: STATUS_OK,
                                     popped_value: VALUE_W'(rd_data_reg)};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                ST_RV_RDJ: begin
                    tmp_next = rd_data_reg;
                    rd_en    = 1'b1;
                    rd_addr  = j_reg;
                    state_next = ST_RV_WRI;
                end
                ST_RV_WRI: begin
                    wr_en       = 1'b1;
                    wr_addr     = i_reg;
                    wr_data     = rd_data_reg;
                    rv_wrj_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rv_wrj_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rv_wrj_reg  <= rv_wrj_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        tmp_reg    <= tmp_next;
        result_reg <= result_next;
    end

endmodule

[sim/lifo_stack_with_reverse_top_tb.sv]
// Self-checking testbench for the LIFO stack with push, pop, clear and in-place reverse.
`timescale 1ns / 100ps

module lifo_stack_with_reverse_top_tb;
    import lifo_rev_pkg::*;

    localparam int STACK_DEPTH = 256;
    localparam int RANDOM_ITEMS = 1050;
    localparam int TAIL_CYCLES = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_WAIT = 17;

    typedef struct {
        func_t              op;
        logic [VALUE_W-1:0] value;
    } stack_req_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = FUNC_PUSH;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    stack_req_t  req_queue[$];
    result_t     result_queue[$];

    // Shadow copy of the stack used to predict each result.
    logic [VALUE_W-1:0] shadow_mem [STACK_DEPTH];
    int                 shadow_fill = 0;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int idle_cycles = 0;
    int err_count = 0;

    lifo_stack_with_reverse_top #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Calm stretches run with no idling at all; they start and stop at random.
    function automatic int draw_wait(ref bit calm);
        if ($urandom_range(0, 39) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic result_t apply_stack_op(func_t op, logic [VALUE_W-1:0] value);
        result_t            res;
        logic [VALUE_W-1:0] tmp;
        res = '0;
        res.status = STATUS_OK;
        case (op)
            FUNC_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_mem[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            FUNC_POP: begin
                if (shadow_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    shadow_fill--;
                    res.popped_value = shadow_mem[shadow_fill];
                end
            end
            FUNC_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
                for (int i = 0; i < shadow_fill / 2; i++) begin
                    tmp = shadow_mem[i];
                    shadow_mem[i] = shadow_mem[shadow_fill - 1 - i];
                    shadow_mem[shadow_fill - 1 - i] = tmp;
                end
            end
        endcase
        res.fill_count = shadow_fill[FILL_W-1:0];
        res.is_empty = (shadow_fill == 0);
        return res;
    endfunction

    task automatic add_req(func_t op, logic [VALUE_W-1:0] value);
        stack_req_t r;
        r.op = op;
        r.value = value;
        req_queue = {req_queue, r};
    endtask

    function automatic func_t pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 42) return FUNC_PUSH;
        if (w < 77) return FUNC_POP;
        if (w < 82) return FUNC_CLEAR;
        return FUNC_REVERSE;
    endfunction

    // Input side: hold an item until it is taken, then wait a drawn gap.
    always @(negedge aclk) begin
        stack_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && in_taken) begin
                send_gap = draw_wait(send_calm);
            end
            if (s_tvalid && !in_taken) begin
                // Item still waiting for s_tready.
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                r = req_queue.pop_front();
                s_tdata <= r.value;
                s_tuser <= r.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: after each item taken, stall for a drawn number of cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                recv_gap = draw_wait(recv_calm);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                want = apply_stack_op(func_t'(s_tuser), s_tdata[VALUE_W-1:0]);
                result_queue = {result_queue, want};
            end
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (result_queue.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    err_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (got.popped_value !== want.popped_value) begin
                        $error("popped_value: expected %h, got %h",
                               want.popped_value, got.popped_value);
                        err_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, got.fill_count);
                        err_count++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
                        err_count++;
                    end
                end
            end
            idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int queued;
        int fills_done;
        int extra;

        // Directed part: empty-stack errors, data extremes, short and even reverses.
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_CLEAR, 32'h0);
        add_req(FUNC_REVERSE, 32'h0);
        add_req(FUNC_PUSH, 32'h8000_0000);
        add_req(FUNC_REVERSE, 32'h0);
        add_req(FUNC_PUSH, 32'h7fff_ffff);
        add_req(FUNC_PUSH, 32'h0000_0000);
        add_req(FUNC_PUSH, 32'hffff_ffff);
        add_req(FUNC_REVERSE, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_PUSH, 32'h5555_5555);
        add_req(FUNC_PUSH, 32'haaaa_aaaa);
        add_req(FUNC_REVERSE, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_POP, 32'h0);
        add_req(FUNC_PUSH, 32'h1234_5678);
        add_req(FUNC_PUSH, 32'h0000_0001);
        add_req(FUNC_CLEAR, 32'h0);
        add_req(FUNC_POP, 32'h0);

        // Random part: mostly mixed traffic, with two passes that fill the
        // stack to the top, push into a full stack and reverse all of it.
        queued = 0;
        fills_done = 0;
        while (queued < RANDOM_ITEMS) begin
            if (fills_done < 2 && queued >= 200 + fills_done * 450) begin
                add_req(FUNC_CLEAR, pick_value());
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    add_req(FUNC_PUSH, pick_value());
                end
                extra = $urandom_range(1, 4);
                for (int i = 0; i < extra; i++) begin
                    add_req(FUNC_PUSH, pick_value());
                end
                add_req(FUNC_REVERSE, pick_value());
                add_req(FUNC_PUSH, pick_value());
                add_req(FUNC_POP, pick_value());
                add_req(FUNC_PUSH, pick_value());
                queued += STACK_DEPTH + extra + 5;
                fills_done++;
            end else begin
                for (int i = 0; i < 20; i++) begin
                    add_req(pick_op(), pick_value());
                end
                queued += 20;
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0 || s_tvalid || result_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (result_queue.size() != 0) begin
            $error("%0d expected results never arrived", result_queue.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/lifo_rev_pkg.sv
rtl/core/lifo_stack_with_reverse_top.sv
sim/lifo_stack_with_reverse_top_tb.sv
